// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clk edge, off while arst_n is low.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Expression that must never be true.
`define ASSERT_NEVER(label, expr, msg) \
	`ASSERT_CLK(label, !(expr), msg)

`endif

// ===== rtl/pfa_pkg.sv =====
// Shared constants, types and microcode ROM for the page frame allocator.
`timescale 1ns / 1ps
package pfa_pkg;

	localparam int NUM_PAGES  = 4096;
	localparam int COUNT_BITS = 8;
	localparam int PAGE_W     = $clog2(NUM_PAGES);
	localparam int DEPTH_W    = $clog2(NUM_PAGES + 1);
	localparam int PIN_W      = 16;
	localparam int FUNC_W     = 3;
	localparam int STAT_W     = 2;
	localparam int REF_W      = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;
	localparam int IN_DATA_W  = ((PIN_W + 7) / 8) * 8;
	localparam int OUT_PAY_W  = STAT_W + PAGE_W + REF_W + 1 + DEPTH_W;
	localparam int OUT_DATA_W = ((OUT_PAY_W + 7) / 8) * 8;
	localparam int UPC_W      = 4;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_TRACK = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 2'd2;

	localparam logic [CFG_DATA_W-1:0] LIMIT_RST = 13'd4096;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_SEED,
		OP_ALLOC,
		OP_FREE,
		OP_INC,
		OP_DEC,
		OP_GET,
		OP_NOP
	} op_t;

	typedef enum logic [1:0] {
		C_ALWAYS,
		C_DISP,
		C_CLR,
		C_EMIT
	} cond_t;

	typedef logic [UPC_W-1:0] upc_t;

	// step addresses; dispatch lands on U_SEED + func
	localparam upc_t U_CLR      = 4'd0;
	localparam upc_t U_IDLE     = 4'd1;
	localparam upc_t U_SEED     = 4'd2;
	localparam upc_t U_ALLOC_RD = 4'd3;
	localparam upc_t U_FREE     = 4'd4;
	localparam upc_t U_INC      = 4'd5;
	localparam upc_t U_DEC      = 4'd6;
	localparam upc_t U_GET      = 4'd7;
	localparam upc_t U_NOP6     = 4'd8;
	localparam upc_t U_NOP7     = 4'd9;
	localparam upc_t U_ALLOC    = 4'd10;

	typedef struct packed {
		cond_t cond;
		upc_t  target;
		logic  in_rdy;
		logic  rd_cnt_stk;
		logic  clr;
		op_t   op;
	} uword_t;

	typedef struct packed {
		logic out_free;
		logic clr_last;
	} dp_stat_t;

	typedef struct packed {
		logic                  track;
		logic [CFG_DATA_W-1:0] first_page;
		logic [CFG_DATA_W-1:0] page_limit;
	} cfg_t;

	function automatic uword_t ucode_rom(upc_t a);
		uword_t w;
		w = '{cond: C_ALWAYS, target: U_IDLE, in_rdy: 1'b0, rd_cnt_stk: 1'b0,
			clr: 1'b0, op: OP_NONE};
		case (a)
			U_CLR: begin
				w.cond = C_CLR;
				w.clr  = 1'b1;
			end
			U_IDLE: begin
				w.cond   = C_DISP;
				w.target = U_SEED;
				w.in_rdy = 1'b1;
			end
			U_SEED: begin
				w.cond = C_EMIT;
				w.op   = OP_SEED;
			end
			U_ALLOC_RD: begin
				w.target     = U_ALLOC;
				w.rd_cnt_stk = 1'b1;
			end
			U_FREE: begin
				w.cond = C_EMIT;
				w.op   = OP_FREE;
			end
			U_INC: begin
				w.cond = C_EMIT;
				w.op   = OP_INC;
			end
			U_DEC: begin
				w.cond = C_EMIT;
				w.op   = OP_DEC;
			end
			U_GET: begin
				w.cond = C_EMIT;
				w.op   = OP_GET;
			end
			U_NOP6, U_NOP7: begin
				w.cond = C_EMIT;
				w.op   = OP_NOP;
			end
			U_ALLOC: begin
				w.cond = C_EMIT;
				w.op   = OP_ALLOC;
			end
			default: begin
				w.cond = C_ALWAYS;
			end
		endcase
		return w;
	endfunction

endpackage

// ===== rtl/pfa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module pfa_ram #(
	parameter int WIDTH  = 8,
	parameter int DEPTH  = 256,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/pfa_useq.sv =====
// Microcode sequencer: step counter, control ROM and jump logic.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pfa_useq (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_fire,
	input  logic [pfa_pkg::FUNC_W-1:0] func,
	input  pfa_pkg::dp_stat_t          stat,
	output pfa_pkg::uword_t            ctrl
);

	pfa_pkg::upc_t upc_q;
	pfa_pkg::upc_t upc_nxt;

	assign ctrl = pfa_pkg::ucode_rom(upc_q);

	always_comb begin
		upc_nxt = upc_q;
		case (ctrl.cond)
			pfa_pkg::C_ALWAYS: upc_nxt = ctrl.target;
			pfa_pkg::C_DISP: begin
				if (in_fire) begin
					upc_nxt = ctrl.target + pfa_pkg::UPC_W'(func);
				end
			end
			pfa_pkg::C_CLR: begin
				if (stat.clr_last) begin
					upc_nxt = ctrl.target;
				end
			end
			pfa_pkg::C_EMIT: begin
				if (stat.out_free) begin
					upc_nxt = ctrl.target;
				end
			end
			default: upc_nxt = pfa_pkg::U_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= pfa_pkg::U_CLR;
		end else begin
			upc_q <= upc_nxt;
		end
	end

	`ASSERT_CLK(a_fire_leaves_idle, in_fire |=> (upc_q != pfa_pkg::U_IDLE), "accept did not dispatch")
	`ASSERT_NEVER(a_no_fire_in_clear, in_fire && (upc_q == pfa_pkg::U_CLR), "accept during clear")

endmodule

// ===== rtl/pfa_dpath.sv =====
// Datapath: free stack and count RAMs, stack depth, clear counter, result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pfa_dpath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  pfa_pkg::uword_t                ctrl,
	input  pfa_pkg::cfg_t                  cfg,
	input  logic                           in_fire,
	input  logic [pfa_pkg::PIN_W-1:0]      in_page,
	output pfa_pkg::dp_stat_t              stat,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [pfa_pkg::OUT_DATA_W-1:0] m_tdata
);

	localparam int PW = pfa_pkg::PAGE_W;
	localparam int DW = pfa_pkg::DEPTH_W;
	localparam int CB = pfa_pkg::COUNT_BITS;

	logic [DW-1:0]                   depth_q;
	logic [PW-1:0]                   clr_q;
	logic                            m_tvalid_q;
	logic [pfa_pkg::PIN_W-1:0]       page_q;
	logic [PW-1:0]                   pg_q;
	logic [pfa_pkg::OUT_PAY_W-1:0]   out_q;

	logic [PW-1:0] stk_rdata;
	logic [CB-1:0] cnt_rdata;
	logic [PW-1:0] cnt_raddr;
	logic          cnt_re;
	logic          cnt_we;
	logic [PW-1:0] cnt_waddr;
	logic [CB-1:0] cnt_wdata;

	logic                         ex_go;
	logic                         push;
	logic                         pop;
	logic [CB-1:0]                nxt_cnt;
	logic [CB-1:0]                dec_cnt;
	logic                         ex_cnt_we;
	logic [pfa_pkg::STAT_W-1:0]   ex_status;
	logic [PW-1:0]                ex_apage;
	logic [pfa_pkg::REF_W-1:0]    ex_ref;
	logic                         ex_rel;
	logic                         full;
	logic                         empty;
	logic                         pg_oor;
	logic                         free_oor;
	logic [PW-1:0]                pg_idx;
	logic [DW-1:0]                depth_nxt;

	assign stat.out_free = !m_tvalid_q || m_tready;
	assign stat.clr_last = (clr_q == PW'(pfa_pkg::NUM_PAGES - 1));
	assign ex_go         = (ctrl.op != pfa_pkg::OP_NONE) && stat.out_free;

	assign full     = (depth_q == DW'(pfa_pkg::NUM_PAGES));
	assign empty    = (depth_q == '0);
	assign pg_idx   = page_q[PW-1:0];
	assign pg_oor   = (32'(page_q) >= pfa_pkg::NUM_PAGES);
	assign free_oor = pg_oor || (page_q < pfa_pkg::PIN_W'(cfg.first_page))
		|| (page_q >= pfa_pkg::PIN_W'(cfg.page_limit));
	assign dec_cnt  = (cnt_rdata == '0) ? '0 : cnt_rdata - CB'(1);

	always_comb begin
		push      = 1'b0;
		pop       = 1'b0;
		nxt_cnt   = cnt_rdata;
		ex_cnt_we = 1'b0;
		ex_status = pfa_pkg::ST_OK;
		ex_apage  = '0;
		ex_ref    = '0;
		ex_rel    = 1'b0;
		case (ctrl.op)
			pfa_pkg::OP_SEED: begin
				if (full) begin
					ex_status = pfa_pkg::ST_FULL;
				end else begin
					push   = 1'b1;
					ex_rel = 1'b1;
				end
			end
			pfa_pkg::OP_ALLOC: begin
				if (empty) begin
					ex_status = pfa_pkg::ST_EMPTY;
				end else begin
					pop      = 1'b1;
					ex_apage = pg_q;
					if (cfg.track) begin
						nxt_cnt   = (cnt_rdata == '0) ? CB'(1) : cnt_rdata;
						ex_cnt_we = 1'b1;
						ex_ref    = pfa_pkg::REF_W'(nxt_cnt);
					end
				end
			end
			pfa_pkg::OP_FREE: begin
				if (free_oor) begin
					ex_status = pfa_pkg::ST_RANGE;
				end else begin
					if (cfg.track) begin
						nxt_cnt   = dec_cnt;
						ex_cnt_we = 1'b1;
						ex_ref    = pfa_pkg::REF_W'(dec_cnt);
					end
					if (!cfg.track || (dec_cnt == '0)) begin
						if (full) begin
							ex_status = pfa_pkg::ST_FULL;
						end else begin
							push   = 1'b1;
							ex_rel = 1'b1;
						end
					end
				end
			end
			pfa_pkg::OP_INC, pfa_pkg::OP_DEC, pfa_pkg::OP_GET: begin
				if (pg_oor) begin
					ex_status = pfa_pkg::ST_RANGE;
				end else if (cfg.track) begin
					if (ctrl.op == pfa_pkg::OP_INC) begin
						if (cnt_rdata == '0) begin
							nxt_cnt = CB'(2);
						end else if (cnt_rdata != '1) begin
							nxt_cnt = cnt_rdata + CB'(1);
						end
						ex_cnt_we = 1'b1;
					end else if (ctrl.op == pfa_pkg::OP_DEC) begin
						nxt_cnt   = dec_cnt;
						ex_cnt_we = 1'b1;
					end
					ex_ref = pfa_pkg::REF_W'(nxt_cnt);
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		depth_nxt = depth_q;
		if (push) begin
			depth_nxt = depth_q + DW'(1);
		end else if (pop) begin
			depth_nxt = depth_q - DW'(1);
		end
	end

	assign cnt_re    = in_fire || ctrl.rd_cnt_stk;
	assign cnt_raddr = ctrl.rd_cnt_stk ? stk_rdata : in_page[PW-1:0];
	assign cnt_we    = ctrl.clr || (ex_go && ex_cnt_we);
	assign cnt_waddr = ctrl.clr ? clr_q
		: ((ctrl.op == pfa_pkg::OP_ALLOC) ? pg_q : pg_idx);
	assign cnt_wdata = ctrl.clr ? '0 : nxt_cnt;

	pfa_ram #(
		.WIDTH(PW),
		.DEPTH(pfa_pkg::NUM_PAGES)
	) u_stack_ram (
		.clk   (clk),
		.we    (ex_go && push),
		.waddr (depth_q[PW-1:0]),
		.wdata (pg_idx),
		.re    (in_fire),
		.raddr (PW'(depth_q - DW'(1))),
		.rdata (stk_rdata)
	);

	pfa_ram #(
		.WIDTH(CB),
		.DEPTH(pfa_pkg::NUM_PAGES)
	) u_count_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.re    (cnt_re),
		.raddr (cnt_raddr),
		.rdata (cnt_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q    <= '0;
			clr_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (ctrl.clr) begin
				clr_q <= clr_q + PW'(1);
			end
			if (ex_go) begin
				depth_q    <= depth_nxt;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			page_q <= in_page;
		end
		if (ctrl.rd_cnt_stk) begin
			pg_q <= stk_rdata;
		end
		if (ex_go) begin
			out_q <= {depth_nxt, ex_rel, ex_ref, ex_apage, ex_status};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = pfa_pkg::OUT_DATA_W'(out_q);

	`ASSERT_NEVER(a_depth_max, depth_q > DW'(pfa_pkg::NUM_PAGES), "stack depth overflow")
	`ASSERT_CLK(a_depth_hold, !ex_go |=> $stable(depth_q), "depth moved without a request")
	`ASSERT_NEVER(a_push_pop, push && pop, "push and pop in one step")

endmodule

// ===== rtl/page_frame_allocator_refcount_unit.sv =====
// Top level of the page frame allocator with per-page reference counts.
`timescale 1ns / 1ps
// Page frame allocator: free pages sit on a LIFO stack RAM, each page has an
// 8-bit reference count in a second RAM, and a small microcode ROM sequences
// each request. After reset the count RAM is cleared one entry per cycle, so
// s_tready stays low until the clear ends (config writes are taken throughout).
// A request is accepted and then executed from the registered RAM reads; alloc
// adds a count read step in between since that read depends on the popped page.
// Results go to an output register; a held result stalls the execute step.
module page_frame_allocator_refcount_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [pfa_pkg::IN_DATA_W-1:0]     s_tdata,   // [15:0] page
	input  logic [pfa_pkg::FUNC_W-1:0]        s_tuser,   // [2:0] func
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [1:0] status, [13:2] alloc_page, [21:14] ref_value, [22] page_released,
	// [35:23] free_pages, rest zero
	output logic [pfa_pkg::OUT_DATA_W-1:0]    m_tdata,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [pfa_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pfa_pkg::CFG_DATA_W-1:0]    cfg_data
);

	pfa_pkg::uword_t   ctrl;
	pfa_pkg::dp_stat_t stat;
	pfa_pkg::cfg_t     cfg_q;
	logic              in_fire;

	assign s_tready  = ctrl.in_rdy;
	assign in_fire   = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.track      <= 1'b0;
			cfg_q.first_page <= '0;
			cfg_q.page_limit <= pfa_pkg::LIMIT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				pfa_pkg::CFG_TRACK: cfg_q.track      <= cfg_data[0];
				pfa_pkg::CFG_FIRST: cfg_q.first_page <= cfg_data;
				pfa_pkg::CFG_LIMIT: cfg_q.page_limit <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	pfa_useq u_useq (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_fire (in_fire),
		.func    (s_tuser),
		.stat    (stat),
		.ctrl    (ctrl)
	);

	pfa_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.cfg      (cfg_q),
		.in_fire  (in_fire),
		.in_page  (s_tdata[pfa_pkg::PIN_W-1:0]),
		.stat     (stat),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule
